@@ hw/rtl/sfs_pkg.sv @@
package sfs_pkg;

    // Clip and sheet limits.
    localparam int MAX_FRAMES = 64;
    localparam int FRAME_W    = 6;
    localparam int CELL_BITS  = 10;
    localparam int COUNT_W    = 7;

    // Field widths.
    localparam int OP_W      = 2;
    localparam int TICK_W    = 16;
    localparam int RATE_W    = 15;
    localparam int COLS_W    = 10;
    localparam int DIM_W     = 12;
    localparam int COORD_W   = 22;
    localparam int PHASE_W   = 32;
    localparam int STEP_W    = 23;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 15;

    // Shared divider: 16-bit dividend, one quotient bit per cycle.
    localparam int DIV_N_W   = 16;
    localparam int DIV_D_W   = 10;
    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = 4;

    // Request opcodes.
    localparam logic [OP_W-1:0] OP_TICK = 2'd0;
    localparam logic [OP_W-1:0] OP_PLAY = 2'd1;
    localparam logic [OP_W-1:0] OP_STOP = 2'd2;
    localparam logic [OP_W-1:0] OP_LOAD = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_FPS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHEET_COLUMNS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT   = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic prod;
        logic add;
        logic clamp;
        logic div_phase;
        logic wrap;
        logic commit;
        logic play;
        logic stop;
        logic load;
        logic div_cell;
        logic xy;
        logic emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            tick_inert;
        logic            loop;
        logic            changed;
        logic            count_zero;
        logic            cols_zero;
        logic            div_busy;
    } t_status;

endpackage

@@ hw/rtl/sfs_ctrl.sv @@
module sfs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_free,
    input  sfs_pkg::t_status i_status,
    output logic             o_in_ready,
    output sfs_pkg::t_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_ADD   = 4'd2;
    localparam logic [3:0] S_NEXT  = 4'd3;
    localparam logic [3:0] S_WAITP = 4'd4;
    localparam logic [3:0] S_WRAP  = 4'd5;
    localparam logic [3:0] S_CHK   = 4'd6;
    localparam logic [3:0] S_RD    = 4'd7;
    localparam logic [3:0] S_DIVC  = 4'd8;
    localparam logic [3:0] S_WAITC = 4'd9;
    localparam logic [3:0] S_XY    = 4'd10;
    localparam logic [3:0] S_EMIT  = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DEC;
                end
            end
            S_DEC: begin
                unique case (i_status.op)
                    sfs_pkg::OP_TICK: begin
                        if (i_status.tick_inert) begin
                            n_state = S_IDLE;
                        end else begin
                            o_cmd.prod = 1'b1;
                            n_state    = S_ADD;
                        end
                    end
                    sfs_pkg::OP_PLAY: begin
                        o_cmd.play = 1'b1;
                        if (i_status.count_zero || i_status.cols_zero) begin
                            n_state = S_IDLE;
                        end else begin
                            n_state = S_RD;
                        end
                    end
                    sfs_pkg::OP_STOP: begin
                        o_cmd.stop = 1'b1;
                        n_state    = S_IDLE;
                    end
                    default: begin
                        o_cmd.load = 1'b1;
                        n_state    = S_IDLE;
                    end
                endcase
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_NEXT;
            end
            S_NEXT: begin
                if (i_status.loop) begin
                    o_cmd.div_phase = 1'b1;
                    n_state         = S_WAITP;
                end else begin
                    o_cmd.clamp = 1'b1;
                    n_state     = S_CHK;
                end
            end
            S_WAITP: begin
                if (!i_status.div_busy) begin
                    n_state = S_WRAP;
                end
            end
            S_WRAP: begin
                o_cmd.wrap = 1'b1;
                n_state    = S_CHK;
            end
            S_CHK: begin
                if (i_status.changed) begin
                    o_cmd.commit = 1'b1;
                    n_state      = i_status.cols_zero ? S_IDLE : S_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RD: begin
                n_state = S_DIVC;
            end
            S_DIVC: begin
                o_cmd.div_cell = 1'b1;
                n_state        = S_WAITC;
            end
            S_WAITC: begin
                if (!i_status.div_busy) begin
                    n_state = S_XY;
                end
            end
            S_XY: begin
                o_cmd.xy = 1'b1;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (i_out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/sfs_dpath.sv @@
module sfs_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sfs_pkg::t_cmd                       i_cmd,
    input  logic                                i_cfg_we,
    input  logic [sfs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sfs_pkg::CFG_DAT_W-1:0]       i_cfg_data,
    input  logic [sfs_pkg::OP_W-1:0]            i_opcode,
    input  logic [sfs_pkg::TICK_W-1:0]          i_tick_time,
    input  logic [sfs_pkg::FRAME_W-1:0]         i_entry_index,
    input  logic [sfs_pkg::CELL_BITS-1:0]       i_entry_cell,
    output sfs_pkg::t_status                    o_status,
    output logic [sfs_pkg::COORD_W-1:0]         o_x,
    output logic [sfs_pkg::COORD_W-1:0]         o_y,
    output logic [sfs_pkg::FRAME_W-1:0]         o_frame,
    output logic                                o_running,
    output logic                                o_done
);

    // Configuration registers.
    logic [sfs_pkg::COUNT_W-1:0] r_frame_count;
    logic [sfs_pkg::RATE_W-1:0]  r_rate;
    logic                        r_loop;
    logic [sfs_pkg::COLS_W-1:0]  r_cols;
    logic [sfs_pkg::DIM_W-1:0]   r_cell_w;
    logic [sfs_pkg::DIM_W-1:0]   r_cell_h;

    // Captured request.
    logic [sfs_pkg::OP_W-1:0]      r_op;
    logic [sfs_pkg::TICK_W-1:0]    r_dt;
    logic [sfs_pkg::FRAME_W-1:0]   r_slot;
    logic [sfs_pkg::CELL_BITS-1:0] r_cell;

    // Playback state.
    logic [sfs_pkg::PHASE_W-1:0] r_phase;
    logic [sfs_pkg::FRAME_W-1:0] r_cur;
    logic [sfs_pkg::FRAME_W-1:0] r_new_idx;
    logic                        r_running;
    logic                        r_done;
    logic [sfs_pkg::STEP_W-1:0]  r_step;

    // Frame table and its registered read port.
    logic [sfs_pkg::CELL_BITS-1:0] r_table [sfs_pkg::MAX_FRAMES];
    logic [sfs_pkg::CELL_BITS-1:0] r_rd;

    // Shared divider.
    logic                          r_div_busy;
    logic [sfs_pkg::DIV_CNT_W-1:0] r_div_cnt;
    logic [sfs_pkg::DIV_D_W-1:0]   r_div_rem;
    logic [sfs_pkg::DIV_D_W-1:0]   r_div_den;
    logic [sfs_pkg::DIV_N_W-1:0]   r_div_quo;
    logic [sfs_pkg::DIV_D_W:0]     div_shift;
    logic [sfs_pkg::DIV_D_W:0]     div_diff;
    logic                          div_ge;

    logic [sfs_pkg::COORD_W-1:0]   r_x;
    logic [sfs_pkg::COORD_W-1:0]   r_y;

    logic [sfs_pkg::COUNT_W-1:0]   count_live;
    logic [30:0]                   prod_full;
    logic [sfs_pkg::PHASE_W:0]     sum;
    logic [sfs_pkg::TICK_W-1:0]    phase_int;
    logic                          at_end;

    // Frame counts above the table depth behave as a full table.
    assign count_live = (r_frame_count > sfs_pkg::COUNT_W'(sfs_pkg::MAX_FRAMES))
                      ? sfs_pkg::COUNT_W'(sfs_pkg::MAX_FRAMES) : r_frame_count;
    assign prod_full  = 31'(r_dt) * 31'(r_rate);
    assign sum        = {1'b0, r_phase} + (sfs_pkg::PHASE_W + 1)'(r_step);
    assign phase_int  = r_phase[sfs_pkg::PHASE_W-1:sfs_pkg::TICK_W];
    assign at_end     = phase_int >= sfs_pkg::TICK_W'(count_live);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= '0;
            r_rate        <= '0;
            r_loop        <= 1'b0;
            r_cols        <= '0;
            r_cell_w      <= '0;
            r_cell_h      <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sfs_pkg::CFG_FRAME_COUNT:   r_frame_count <= i_cfg_data[sfs_pkg::COUNT_W-1:0];
                sfs_pkg::CFG_RATE_FPS:      r_rate        <= i_cfg_data[sfs_pkg::RATE_W-1:0];
                sfs_pkg::CFG_LOOP_ENABLE:   r_loop        <= i_cfg_data[0];
                sfs_pkg::CFG_SHEET_COLUMNS: r_cols        <= i_cfg_data[sfs_pkg::COLS_W-1:0];
                sfs_pkg::CFG_CELL_WIDTH:    r_cell_w      <= i_cfg_data[sfs_pkg::DIM_W-1:0];
                sfs_pkg::CFG_CELL_HEIGHT:   r_cell_h      <= i_cfg_data[sfs_pkg::DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_opcode;
            r_dt   <= i_tick_time;
            r_slot <= i_entry_index;
            r_cell <= i_entry_cell;
        end
        if (i_cmd.prod) begin
            r_step <= prod_full[30:8];
        end
        if (i_cmd.clamp) begin
            r_new_idx <= at_end ? sfs_pkg::FRAME_W'(count_live - 7'd1)
                                : phase_int[sfs_pkg::FRAME_W-1:0];
        end else if (i_cmd.wrap) begin
            r_new_idx <= r_div_rem[sfs_pkg::FRAME_W-1:0];
        end
        if (i_cmd.xy) begin
            r_x <= sfs_pkg::COORD_W'(r_div_rem) * sfs_pkg::COORD_W'(r_cell_w);
            r_y <= sfs_pkg::COORD_W'(r_div_quo[sfs_pkg::DIV_D_W-1:0])
                 * sfs_pkg::COORD_W'(r_cell_h);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= '0;
            r_cur     <= '0;
            r_running <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            if (i_cmd.add) begin
                r_phase <= sum[sfs_pkg::PHASE_W] ? '1 : sum[sfs_pkg::PHASE_W-1:0];
            end else if (i_cmd.wrap) begin
                // The integer part is reduced modulo the frame count; the fraction stays.
                r_phase <= {10'd0, r_div_rem[sfs_pkg::FRAME_W-1:0],
                            r_phase[sfs_pkg::TICK_W-1:0]};
            end else if (i_cmd.play) begin
                r_phase <= '0;
            end
            if (i_cmd.clamp && at_end) begin
                r_running <= 1'b0;
                r_done    <= 1'b1;
            end else if (i_cmd.play) begin
                r_running <= 1'b1;
                r_done    <= 1'b0;
            end else if (i_cmd.stop) begin
                r_running <= 1'b0;
            end
            if (i_cmd.commit) begin
                r_cur <= r_new_idx;
            end else if (i_cmd.play) begin
                r_cur <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_table[r_slot] <= r_cell;
        end
        r_rd <= r_table[r_cur];
    end

    // Restoring divider: one quotient bit per cycle.
    assign div_shift = {r_div_rem, r_div_quo[sfs_pkg::DIV_N_W-1]};
    assign div_ge    = div_shift >= {1'b0, r_div_den};
    assign div_diff  = div_shift - {1'b0, r_div_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
            r_div_cnt  <= '0;
        end else if (i_cmd.div_phase || i_cmd.div_cell) begin
            r_div_busy <= 1'b1;
            r_div_cnt  <= '0;
        end else if (r_div_busy) begin
            r_div_cnt <= r_div_cnt + 1'b1;
            if (r_div_cnt == sfs_pkg::DIV_CNT_W'(sfs_pkg::DIV_STEPS - 1)) begin
                r_div_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_phase) begin
            r_div_rem <= '0;
            r_div_quo <= phase_int;
            r_div_den <= sfs_pkg::DIV_D_W'(count_live);
        end else if (i_cmd.div_cell) begin
            r_div_rem <= '0;
            r_div_quo <= sfs_pkg::DIV_N_W'(r_rd);
            r_div_den <= r_cols;
        end else if (r_div_busy) begin
            r_div_rem <= div_ge ? div_diff[sfs_pkg::DIV_D_W-1:0]
                                : div_shift[sfs_pkg::DIV_D_W-1:0];
            r_div_quo <= {r_div_quo[sfs_pkg::DIV_N_W-2:0], div_ge};
        end
    end

    assign o_status.op         = r_op;
    assign o_status.tick_inert = !r_running || (count_live == '0) || (r_rate == '0);
    assign o_status.loop       = r_loop;
    assign o_status.changed    = r_new_idx != r_cur;
    assign o_status.count_zero = count_live == '0;
    assign o_status.cols_zero  = r_cols == '0;
    assign o_status.div_busy   = r_div_busy;

    assign o_x       = r_x;
    assign o_y       = r_y;
    assign o_frame   = r_cur;
    assign o_running = r_running;
    assign o_done    = r_done;

endmodule

@@ hw/rtl/sprite_frame_sequencer.sv @@
// Sprite sheet frame sequencer.
// Requests arrive on the input channel (i_in_valid / o_in_ready) as an opcode with its
// fields: tick advances the Q16.16 frame phase by tick_time times rate_fps, play restarts
// the clip from frame zero, stop halts playback and load writes one frame table slot.
// Clip and sheet settings are written through i_cfg_we / i_cfg_index / i_cfg_data; the
// user must write them only while the block is idle; the block does not enforce this.
// A tick that shows a new frame, and a play request, yields one result on the output
// channel (o_out_valid / i_out_ready) when the clip has frames and the sheet has columns,
// carrying the cell's source origin on the sheet together with the frame index and the
// playback flags. The block works on one request at a time. Stop, load and inert ticks
// return straight to idle. A looping tick runs the shared 16-step divider for the phase
// wrap and, when it shows a frame, a second time for the cell row and column split; a
// play request or a non-looping tick that shows a frame uses the divider once.
// The result sits in an output register, so the next request is taken while it waits;
// if the receiver still stalls when the next result is ready, the controller holds in
// its emit state and takes no further request until the register frees.
// Reset clears the settings, the phase, the shown frame and the flags; frame table slots
// hold nothing defined until they are loaded.
module sprite_frame_sequencer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sfs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sfs_pkg::CFG_DAT_W-1:0]       i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [sfs_pkg::OP_W-1:0]            i_opcode,
    input  logic [sfs_pkg::TICK_W-1:0]          i_tick_time,
    input  logic [sfs_pkg::FRAME_W-1:0]         i_entry_index,
    input  logic [sfs_pkg::CELL_BITS-1:0]       i_entry_cell,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [sfs_pkg::COORD_W-1:0]         o_src_x,
    output logic [sfs_pkg::COORD_W-1:0]         o_src_y,
    output logic [sfs_pkg::FRAME_W-1:0]         o_shown_frame,
    output logic                                o_is_playing,
    output logic                                o_is_finished
);

    sfs_pkg::t_cmd    cmd;
    sfs_pkg::t_status status;

    logic [sfs_pkg::COORD_W-1:0] dp_x;
    logic [sfs_pkg::COORD_W-1:0] dp_y;
    logic [sfs_pkg::FRAME_W-1:0] dp_frame;
    logic                        dp_running;
    logic                        dp_done;
    logic                        out_free;

    // Output register: a result waits here until the receiver takes it.
    logic                        r_out_valid;
    logic [sfs_pkg::COORD_W-1:0] r_src_x;
    logic [sfs_pkg::COORD_W-1:0] r_src_y;
    logic [sfs_pkg::FRAME_W-1:0] r_shown_frame;
    logic                        r_is_playing;
    logic                        r_is_finished;

    // The register may be reloaded in the same cycle as its old contents leave.
    assign out_free = !r_out_valid || i_out_ready;

    sfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (out_free),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    sfs_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_opcode      (i_opcode),
        .i_tick_time   (i_tick_time),
        .i_entry_index (i_entry_index),
        .i_entry_cell  (i_entry_cell),
        .o_status      (status),
        .o_x           (dp_x),
        .o_y           (dp_y),
        .o_frame       (dp_frame),
        .o_running     (dp_running),
        .o_done        (dp_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.emit) begin
            r_src_x       <= dp_x;
            r_src_y       <= dp_y;
            r_shown_frame <= dp_frame;
            r_is_playing  <= dp_running;
            r_is_finished <= dp_done;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_src_x       = r_src_x;
    assign o_src_y       = r_src_y;
    assign o_shown_frame = r_shown_frame;
    assign o_is_playing  = r_is_playing;
    assign o_is_finished = r_is_finished;

endmodule

@@ dv/sprite_frame_sequencer_test.sv @@
module sprite_frame_sequencer_test;
    timeunit 1ns;
    timeprecision 1ps;

    // The longest request is a looping tick that shows a frame. This margin covers a
    // request that yields no result but is still being worked on.
    localparam int SETTLE_CYCLES    = 64;
    localparam int SEGMENT_REQUESTS = 35;
    localparam int REPORT_LIMIT     = 10;

    // One result as it appears on the output channel.
    typedef struct packed {
        logic [sfs_pkg::COORD_W-1:0] src_x;
        logic [sfs_pkg::COORD_W-1:0] src_y;
        logic [sfs_pkg::FRAME_W-1:0] frame;
        logic                        playing;
        logic                        finished;
    } t_frame_view;

    // The clip and sheet settings, one field per register.
    typedef struct packed {
        logic [sfs_pkg::COUNT_W-1:0] count;
        logic [sfs_pkg::RATE_W-1:0]  rate;
        logic                        loop;
        logic [sfs_pkg::COLS_W-1:0]  cols;
        logic [sfs_pkg::DIM_W-1:0]   cell_w;
        logic [sfs_pkg::DIM_W-1:0]   cell_h;
    } t_clip_cfg;

    // A row of the directed script is either a change of settings or one request. Where the
    // outcome is obvious it is written into the row, otherwise the clip model supplies it.
    typedef struct {
        bit                            is_cfg;
        t_clip_cfg                     cfg;
        logic [sfs_pkg::OP_W-1:0]      op;
        logic [sfs_pkg::TICK_W-1:0]    dt;
        logic [sfs_pkg::FRAME_W-1:0]   slot;
        logic [sfs_pkg::CELL_BITS-1:0] cell_no;
        bit                            typed;
        bit                            shows;
        t_frame_view                   view;
    } t_script_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic [sfs_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [sfs_pkg::CFG_DAT_W-1:0] i_cfg_data = '0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    logic [sfs_pkg::OP_W-1:0]      i_opcode = '0;
    logic [sfs_pkg::TICK_W-1:0]    i_tick_time = '0;
    logic [sfs_pkg::FRAME_W-1:0]   i_entry_index = '0;
    logic [sfs_pkg::CELL_BITS-1:0] i_entry_cell = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    logic [sfs_pkg::COORD_W-1:0]   o_src_x;
    logic [sfs_pkg::COORD_W-1:0]   o_src_y;
    logic [sfs_pkg::FRAME_W-1:0]   o_shown_frame;
    logic                          o_is_playing;
    logic                          o_is_finished;

    // Our own copy of the clip: settings, phase, shown frame, flags and frame table.
    t_clip_cfg                     clip_cfg = '0;
    logic [sfs_pkg::PHASE_W-1:0]   clip_phase = '0;
    logic [sfs_pkg::FRAME_W-1:0]   clip_frame = '0;
    logic                          clip_running = 1'b0;
    logic                          clip_done = 1'b0;
    logic [sfs_pkg::CELL_BITS-1:0] cell_table [sfs_pkg::MAX_FRAMES];

    // Results still owed by the block, oldest first.
    t_frame_view pending_views[$];
    int          fault_count = 0;
    int          tx_idle_pct = 34;
    int          rx_idle_pct = 72;

    sprite_frame_sequencer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_tick_time   (i_tick_time),
        .i_entry_index (i_entry_index),
        .i_entry_cell  (i_entry_cell),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_src_x       (o_src_x),
        .o_src_y       (o_src_y),
        .o_shown_frame (o_shown_frame),
        .o_is_playing  (o_is_playing),
        .o_is_finished (o_is_finished)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("FAIL sprite_frame_sequencer");
        $finish;
    end

    // A frame count above the table size behaves as a full table.
    function automatic logic [sfs_pkg::COUNT_W-1:0] live_frames();
        return (clip_cfg.count > sfs_pkg::COUNT_W'(sfs_pkg::MAX_FRAMES))
             ? sfs_pkg::COUNT_W'(sfs_pkg::MAX_FRAMES) : clip_cfg.count;
    endfunction

    // Source origin of the shown frame. Nothing is produced when the clip has no frames or
    // the sheet has no columns.
    function automatic bit frame_origin(output t_frame_view view);
        logic [sfs_pkg::CELL_BITS-1:0] cell_no;
        logic [31:0]                   col_px;
        logic [31:0]                   row_px;
        view = '0;
        if (live_frames() == '0 || clip_cfg.cols == '0) return 1'b0;
        cell_no = cell_table[clip_frame];
        col_px = 32'(cell_no % clip_cfg.cols) * 32'(clip_cfg.cell_w);
        row_px = 32'(cell_no / clip_cfg.cols) * 32'(clip_cfg.cell_h);
        view.src_x = col_px[sfs_pkg::COORD_W-1:0];
        view.src_y = row_px[sfs_pkg::COORD_W-1:0];
        view.frame = clip_frame;
        view.playing = clip_running;
        view.finished = clip_done;
        return 1'b1;
    endfunction

    // Applies one request to the clip model and reports whether it yields a result.
    function automatic bit step_clip(input logic [sfs_pkg::OP_W-1:0] op,
                                     input logic [sfs_pkg::TICK_W-1:0] dt,
                                     input logic [sfs_pkg::FRAME_W-1:0] slot,
                                     input logic [sfs_pkg::CELL_BITS-1:0] cell_no,
                                     output t_frame_view view);
        logic [sfs_pkg::PHASE_W:0]   sum;
        logic [sfs_pkg::PHASE_W-1:0] period;
        logic [15:0]                 idx;
        view = '0;
        case (op)
            sfs_pkg::OP_TICK: begin
                // A stopped clip, an empty clip or a zero rate leaves everything as it is.
                if (!clip_running || live_frames() == '0 || clip_cfg.rate == '0) return 1'b0;
                // Seconds times frames per second is Q8.24; drop 8 bits to get Q16.16.
                sum = {1'b0, clip_phase} + 33'((32'(dt) * 32'(clip_cfg.rate)) >> 8);
                clip_phase = sum[sfs_pkg::PHASE_W] ? '1 : sum[sfs_pkg::PHASE_W-1:0];
                if (clip_cfg.loop) begin
                    period = 32'(live_frames()) << 16;
                    clip_phase = clip_phase % period;
                    idx = clip_phase[31:16];
                end else begin
                    idx = clip_phase[31:16];
                    // Past the end the last frame stays shown and playback finishes.
                    if (idx >= 16'(live_frames())) begin
                        idx = 16'(live_frames()) - 16'd1;
                        clip_running = 1'b0;
                        clip_done = 1'b1;
                    end
                end
                if (idx == 16'(clip_frame)) return 1'b0;
                clip_frame = idx[sfs_pkg::FRAME_W-1:0];
                return frame_origin(view);
            end
            sfs_pkg::OP_PLAY: begin
                clip_phase = '0;
                clip_frame = '0;
                clip_running = 1'b1;
                clip_done = 1'b0;
                return frame_origin(view);
            end
            sfs_pkg::OP_STOP: begin
                clip_running = 1'b0;
                return 1'b0;
            end
            sfs_pkg::OP_LOAD: begin
                cell_table[slot] = cell_no;
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic t_clip_cfg clip_settings(input int count, input int rate, input int loop,
                                                input int cols, input int cell_w,
                                                input int cell_h);
        t_clip_cfg c;
        c.count = sfs_pkg::COUNT_W'(count);
        c.rate = sfs_pkg::RATE_W'(rate);
        c.loop = 1'(loop);
        c.cols = sfs_pkg::COLS_W'(cols);
        c.cell_w = sfs_pkg::DIM_W'(cell_w);
        c.cell_h = sfs_pkg::DIM_W'(cell_h);
        return c;
    endfunction

    function automatic t_script_row cfg_row(input t_clip_cfg c);
        t_script_row row;
        row = '{default: 0};
        row.is_cfg = 1'b1;
        row.cfg = c;
        return row;
    endfunction

    function automatic t_script_row rq(input logic [sfs_pkg::OP_W-1:0] op,
                                       input logic [sfs_pkg::TICK_W-1:0] dt,
                                       input logic [sfs_pkg::FRAME_W-1:0] slot,
                                       input logic [sfs_pkg::CELL_BITS-1:0] cell_no);
        t_script_row row;
        row = '{default: 0};
        row.op = op;
        row.dt = dt;
        row.slot = slot;
        row.cell_no = cell_no;
        return row;
    endfunction

    // A request that must yield no result.
    function automatic t_script_row rq_none(input logic [sfs_pkg::OP_W-1:0] op,
                                            input logic [sfs_pkg::TICK_W-1:0] dt);
        t_script_row row;
        row = rq(op, dt, '0, '0);
        row.typed = 1'b1;
        return row;
    endfunction

    // A request whose result is written out by hand.
    function automatic t_script_row rq_view(input logic [sfs_pkg::OP_W-1:0] op,
                                            input logic [sfs_pkg::TICK_W-1:0] dt, input int x,
                                            input int y, input int frame, input bit playing,
                                            input bit finished);
        t_script_row row;
        row = rq(op, dt, '0, '0);
        row.typed = 1'b1;
        row.shows = 1'b1;
        row.view.src_x = sfs_pkg::COORD_W'(x);
        row.view.src_y = sfs_pkg::COORD_W'(y);
        row.view.frame = sfs_pkg::FRAME_W'(frame);
        row.view.playing = playing;
        row.view.finished = finished;
        return row;
    endfunction

    // Presents one request, with random idle cycles in front of it, and records what it
    // should produce once it is accepted. Entered and left just after a falling edge; valid
    // is left high so that the next request can follow without a gap.
    task automatic issue(input t_script_row row);
        t_frame_view view;
        bit          shows;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_opcode = row.op;
        i_tick_time = row.dt;
        i_entry_index = row.slot;
        i_entry_cell = row.cell_no;
        i_in_valid = 1'b1;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        shows = step_clip(row.op, row.dt, row.slot, row.cell_no, view);
        if (row.typed) begin
            shows = row.shows;
            view = row.view;
        end
        if (shows) pending_views.push_back(view);
        @(negedge i_clk);
    endtask

    // Holds off new requests until every owed result has arrived and the block has had time
    // to finish any request that yields none.
    task automatic drain();
        i_in_valid = 1'b0;
        while (pending_views.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [sfs_pkg::CFG_IDX_W-1:0] idx, input int data);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = sfs_pkg::CFG_DAT_W'(data);
        @(negedge i_clk);
    endtask

    // Settings are only changed while the block is idle.
    task automatic reconfigure(input t_clip_cfg c);
        drain();
        write_reg(sfs_pkg::CFG_FRAME_COUNT, c.count);
        write_reg(sfs_pkg::CFG_RATE_FPS, c.rate);
        write_reg(sfs_pkg::CFG_LOOP_ENABLE, c.loop);
        write_reg(sfs_pkg::CFG_SHEET_COLUMNS, c.cols);
        write_reg(sfs_pkg::CFG_CELL_WIDTH, c.cell_w);
        write_reg(sfs_pkg::CFG_CELL_HEIGHT, c.cell_h);
        i_cfg_we = 1'b0;
        clip_cfg = c;
    endtask

    // The receiver drops ready at random; the rate is changed with the idling phase.
    always @(negedge i_clk) i_out_ready <= ($urandom_range(99) >= rx_idle_pct);

    // Every result taken by the receiver is checked against the oldest owed result.
    always @(posedge i_clk) begin : watch_results
        t_frame_view got;
        t_frame_view want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.src_x = o_src_x;
            got.src_y = o_src_y;
            got.frame = o_shown_frame;
            got.playing = o_is_playing;
            got.finished = o_is_finished;
            if (pending_views.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display("%0t: result with none owed: x %0d y %0d frame %0d play %0b fin %0b",
                             $realtime, got.src_x, got.src_y, got.frame, got.playing,
                             got.finished);
            end else begin
                want = pending_views.pop_front();
                if (got.src_x !== want.src_x || got.src_y !== want.src_y ||
                    got.frame !== want.frame || got.playing !== want.playing ||
                    got.finished !== want.finished) begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                        $display({"%0t: mismatch: expected x %0d y %0d frame %0d play %0b ",
                                  "fin %0b, got x %0d y %0d frame %0d play %0b fin %0b"},
                                 $realtime, want.src_x, want.src_y, want.frame, want.playing,
                                 want.finished, got.src_x, got.src_y, got.frame, got.playing,
                                 got.finished);
                end
            end
        end
    end

    initial begin : stimulus
        t_script_row              script[$];
        t_clip_cfg                c;
        int                       pick;
        logic [sfs_pkg::OP_W-1:0] op;

        // Synchronous reset, released on a falling edge.
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Every table slot is loaded before any frame can be shown, so no lookup ever
        // touches a slot that holds nothing defined.
        for (int s = 0; s < sfs_pkg::MAX_FRAMES; s++)
            issue(rq(sfs_pkg::OP_LOAD, sfs_pkg::TICK_W'($urandom), sfs_pkg::FRAME_W'(s),
                     sfs_pkg::CELL_BITS'($urandom)));

        // With the settings at reset the clip is empty: nothing is ever shown.
        script.push_back(rq_none(sfs_pkg::OP_PLAY, '0));
        script.push_back(rq_none(sfs_pkg::OP_TICK, 16'hffff));
        script.push_back(rq_none(sfs_pkg::OP_STOP, '0));

        // Four frames, fastest rate, no looping, widest sheet and largest cells.
        script.push_back(cfg_row(clip_settings(4, 32767, 0, 1023, 4095, 4095)));
        script.push_back(rq(sfs_pkg::OP_LOAD, '0, 6'd0, 10'd1023));
        script.push_back(rq(sfs_pkg::OP_LOAD, '0, 6'd1, 10'd0));
        script.push_back(rq(sfs_pkg::OP_LOAD, '0, 6'd3, 10'd1022));
        script.push_back(rq_view(sfs_pkg::OP_PLAY, '0, 0, 4095, 0, 1'b1, 1'b0));
        // A zero-length tick leaves the same frame on show.
        script.push_back(rq_none(sfs_pkg::OP_TICK, '0));
        // The longest tick runs far past the end: the last frame is shown and play finishes.
        script.push_back(rq_view(sfs_pkg::OP_TICK, 16'hffff, 4185090, 0, 3, 1'b0, 1'b1));
        script.push_back(rq_none(sfs_pkg::OP_TICK, 16'd100));
        script.push_back(rq_view(sfs_pkg::OP_PLAY, '0, 0, 4095, 0, 1'b1, 1'b0));
        script.push_back(rq_view(sfs_pkg::OP_TICK, 16'd1792, 4185090, 0, 3, 1'b1, 1'b0));
        // Running off the end while the last frame is already shown finishes silently.
        script.push_back(rq_none(sfs_pkg::OP_TICK, 16'd512));
        script.push_back(rq_view(sfs_pkg::OP_PLAY, '0, 0, 4095, 0, 1'b1, 1'b0));
        script.push_back(rq_none(sfs_pkg::OP_STOP, '0));
        script.push_back(rq_none(sfs_pkg::OP_TICK, 16'hffff));

        // A frame count beyond the table acts as a full table; the phase wraps.
        script.push_back(cfg_row(clip_settings(127, 32767, 1, 1, 4095, 0)));
        script.push_back(rq_view(sfs_pkg::OP_PLAY, '0, 0, 0, 0, 1'b1, 1'b0));
        script.push_back(rq_view(sfs_pkg::OP_TICK, 16'hffff, 0, 0, 63, 1'b1, 1'b0));
        script.push_back(rq_none(sfs_pkg::OP_TICK, 16'hffff));
        script.push_back(rq(sfs_pkg::OP_TICK, 16'd1, '0, '0));

        // A sheet with no columns shows nothing, and a zero rate makes ticks inert.
        script.push_back(cfg_row(clip_settings(1, 0, 0, 0, 1, 1)));
        script.push_back(rq_none(sfs_pkg::OP_PLAY, '0));
        script.push_back(rq_none(sfs_pkg::OP_TICK, 16'hffff));

        // An empty clip on a usable sheet still shows nothing.
        script.push_back(cfg_row(clip_settings(0, 1, 1, 5, 7, 9)));
        script.push_back(rq_none(sfs_pkg::OP_PLAY, '0));
        script.push_back(rq_none(sfs_pkg::OP_TICK, 16'h8000));

        foreach (script[i]) begin
            if (script[i].is_cfg) reconfigure(script[i].cfg);
            else issue(script[i]);
        end

        // Random part in three idling phases: the receiver idles more than the sender, then
        // the other way round, then neither. Each phase visits the largest settings, the
        // smallest usable ones and a random set. Plays keep restarting the clip so that ticks
        // reach the wrap and the end of the clip over and over.
        for (int ph = 0; ph < 3; ph++) begin
            for (int k = 0; k < 3; k++) begin
                if (k == 0) begin
                    c = clip_settings(127, 32767, 1, 1023, 4095, 4095);
                end else if (k == 1) begin
                    c = clip_settings(1, 1, 0, 1, 0, 0);
                end else begin
                    c.count = ($urandom_range(7) == 0)
                            ? sfs_pkg::COUNT_W'($urandom_range(127))
                            : sfs_pkg::COUNT_W'($urandom_range(1, 16));
                    c.rate = ($urandom_range(7) == 0)
                           ? sfs_pkg::RATE_W'($urandom_range(1, 255))
                           : sfs_pkg::RATE_W'($urandom_range(256, 32767));
                    c.loop = 1'($urandom_range(1));
                    c.cols = ($urandom_range(1) == 0)
                           ? sfs_pkg::COLS_W'($urandom_range(1, 40))
                           : sfs_pkg::COLS_W'($urandom_range(1, 1023));
                    c.cell_w = sfs_pkg::DIM_W'($urandom);
                    c.cell_h = sfs_pkg::DIM_W'($urandom);
                end
                // Waiting for every owed result here also gives the block a quiet spell.
                reconfigure(c);
                tx_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 72 : 0;
                rx_idle_pct = (ph == 0) ? 72 : (ph == 1) ? 34 : 0;
                for (int n = 0; n < SEGMENT_REQUESTS; n++) begin
                    pick = $urandom_range(99);
                    op = (pick < 60) ? sfs_pkg::OP_TICK : (pick < 78) ? sfs_pkg::OP_PLAY :
                         (pick < 88) ? sfs_pkg::OP_STOP : sfs_pkg::OP_LOAD;
                    issue(rq(op,
                             ($urandom_range(3) == 0) ? sfs_pkg::TICK_W'($urandom_range(2047))
                                                      : sfs_pkg::TICK_W'($urandom),
                             sfs_pkg::FRAME_W'($urandom), sfs_pkg::CELL_BITS'($urandom)));
                end
            end
        end

        drain();
        if (fault_count == 0 && pending_views.size() == 0) begin
            $display("PASS sprite_frame_sequencer");
        end else begin
            $display("FAIL sprite_frame_sequencer");
        end
        $finish;
    end

endmodule
